@@ hdl/cau_pkg.sv @@
// Package for the complex arithmetic unit: opcodes, status codes, item types,
// the pipeline record that travels down the divider chain and the 32-bit clamp.
// No dependencies.
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QBITS         = 32;   // quotient bits, one divider cell each
    localparam int SUM_W         = 66;   // width of exact product sums

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_RCP = 3'd4;
    localparam logic [2:0] OP_CNJ = 3'd5;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] y_re;
        logic signed [31:0] y_im;
        logic signed [31:0] z_re;
        logic signed [31:0] z_im;
    } t_in;

    typedef struct packed {
        logic signed [31:0] w_re;
        logic signed [31:0] w_im;
        logic [1:0]         status;
    } t_out;

    // One item in flight. For divide the s fields are the dividend/quotient
    // shift registers; for all other ops they hold the finished result.
    typedef struct packed {
        logic        dv;
        logic        dz;
        logic        sat;
        logic        ovf_re;
        logic        ovf_im;
        logic        neg_re;
        logic        neg_im;
        logic [63:0] den;
        logic [63:0] p_re;
        logic [63:0] p_im;
        logic [31:0] s_re;
        logic [31:0] s_im;
    } t_stage;

    typedef struct packed {
        logic [31:0] v;
        logic        s;
    } t_sat;

    function automatic t_sat sat32(input logic signed [SUM_W-1:0] x);
        t_sat r;
        if (x > SUM_W'(W_MAX)) begin
            r.v = W_MAX;
            r.s = 1'b1;
        end else if (x < SUM_W'(W_MIN)) begin
            r.v = W_MIN;
            r.s = 1'b1;
        end else begin
            r.v = x[31:0];
            r.s = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ hdl/cau_front.sv @@
// Front end of the complex arithmetic unit: operand register, six products,
// exact sums, simple-op results and divider setup. Depends on cau_pkg.
module cau_front import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_in    i_item,
    output logic   o_vld,
    output t_stage o_stage
);

    logic               r_v0, r_v1, r_v2;
    logic [2:0]         r_op0, r_op1;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [31:0] r_a1, r_b1, r_c1, r_d1;
    logic signed [63:0] r_ac, r_bd, r_ad, r_bc, r_cc, r_dd;
    t_stage             r_st;

    logic signed [31:0] n_a, n_b;
    logic signed [SUM_W-1:0] e_ac, e_bd, e_ad, e_bc;
    logic signed [SUM_W-1:0] mre, mim, nre, nim, abs_re, abs_im;
    logic [63:0] den, mag_re, mag_im, xh_re, xh_im;
    t_sat        s0, s1;
    t_stage      n_st;

    // Reciprocal is a divide of 1.0 by z.
    always_comb begin
        n_a = i_item.y_re;
        n_b = i_item.y_im;
        if (i_item.op == OP_RCP) begin
            n_a = 32'sd1 <<< FRAC_BITS;
            n_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_vld;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_op0 <= i_item.op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= i_item.z_re;
        r_d   <= i_item.z_im;
        r_op1 <= r_op0;
        r_a1  <= r_a;
        r_b1  <= r_b;
        r_c1  <= r_c;
        r_d1  <= r_d;
        r_ac  <= r_a * r_c;
        r_bd  <= r_b * r_d;
        r_ad  <= r_a * r_d;
        r_bc  <= r_b * r_c;
        r_cc  <= r_c * r_c;
        r_dd  <= r_d * r_d;
        r_st  <= n_st;
    end

    always_comb begin
        e_ac   = SUM_W'(r_ac);
        e_bd   = SUM_W'(r_bd);
        e_ad   = SUM_W'(r_ad);
        e_bc   = SUM_W'(r_bc);
        mre    = e_ac - e_bd;
        mim    = e_ad + e_bc;
        nre    = e_ac + e_bd;
        nim    = e_bc - e_ad;
        den    = $unsigned(r_cc) + $unsigned(r_dd);
        abs_re = nre[SUM_W-1] ? -nre : nre;
        abs_im = nim[SUM_W-1] ? -nim : nim;
        mag_re = abs_re[63:0];
        mag_im = abs_im[63:0];
        xh_re  = mag_re >> (32 - FRAC_BITS);
        xh_im  = mag_im >> (32 - FRAC_BITS);

        n_st        = '0;
        n_st.den    = den;
        n_st.dz     = (den == '0);
        n_st.neg_re = nre[SUM_W-1];
        n_st.neg_im = nim[SUM_W-1];
        n_st.ovf_re = (xh_re >= den);
        n_st.ovf_im = (xh_im >= den);
        n_st.p_re   = xh_re;
        n_st.p_im   = xh_im;
        s0 = '0;
        s1 = '0;
        unique case (r_op1)
            OP_ADD: begin
                s0 = sat32(SUM_W'(r_a1) + SUM_W'(r_c1));
                s1 = sat32(SUM_W'(r_b1) + SUM_W'(r_d1));
            end
            OP_SUB: begin
                s0 = sat32(SUM_W'(r_a1) - SUM_W'(r_c1));
                s1 = sat32(SUM_W'(r_b1) - SUM_W'(r_d1));
            end
            OP_MUL: begin
                s0 = sat32(mre >>> FRAC_BITS);
                s1 = sat32(mim >>> FRAC_BITS);
            end
            OP_CNJ: begin
                s0 = sat32(SUM_W'(r_c1));
                s1 = sat32(-SUM_W'(r_d1));
            end
            default: begin
            end
        endcase
        if (r_op1 == OP_DIV || r_op1 == OP_RCP) begin
            n_st.dv   = 1'b1;
            n_st.s_re = {mag_re[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
            n_st.s_im = {mag_im[31-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        end else begin
            n_st.sat  = s0.s | s1.s;
            n_st.s_re = s0.v;
            n_st.s_im = s1.v;
        end
    end

    assign o_vld   = r_v2;
    assign o_stage = r_st;

endmodule

@@ hdl/cau_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit for both parts.
// Depends on cau_pkg.
module cau_div_cell import cau_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_stage i_stage,
    output logic   o_vld,
    output t_stage o_stage
);

    logic         r_vld;
    t_stage       r_st, n_st;
    logic [63:0]  pp_re, pp_im;
    logic [64:0]  df_re, df_im;

    always_comb begin
        pp_re = {i_stage.p_re[62:0], i_stage.s_re[31]};
        pp_im = {i_stage.p_im[62:0], i_stage.s_im[31]};
        df_re = {1'b0, pp_re} - {1'b0, i_stage.den};
        df_im = {1'b0, pp_im} - {1'b0, i_stage.den};
        n_st  = i_stage;
        // Advance the divide; hold finished results of other ops.
        if (i_stage.dv) begin
            n_st.p_re = df_re[64] ? pp_re : df_re[63:0];
            n_st.p_im = df_im[64] ? pp_im : df_im[63:0];
            n_st.s_re = {i_stage.s_re[30:0], ~df_re[64]};
            n_st.s_im = {i_stage.s_im[30:0], ~df_im[64]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_st <= n_st;
    end

    assign o_vld   = r_vld;
    assign o_stage = r_st;

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit top level: front end, a chain of QBITS divider cells
// and the output register. Depends on cau_pkg, cau_front and cau_div_cell.
// Every op passes 3 front stages, 32 divider cells and 1 output stage from start
// to o_done. Throughput: one item per cycle; busy
// stays low. The receiver cannot stall: o_done marks a result for one cycle.
// Reset (synchronous, active low) drops every item in flight.
module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_result
);

    // Stage records along the cell chain; entry 0 comes from the front end.
    logic   c_vld [QBITS+1];
    t_stage c_st  [QBITS+1];

    logic   r_done;
    t_out   r_res, n_res;
    t_stage last;
    t_sat   q_re, q_im;

    // Every cycle is open for a new item.
    assign busy = 1'b0;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_item  (i_item),
        .o_vld   (c_vld[0]),
        .o_stage (c_st[0])
    );

    // One quotient bit per cell, most significant first.
    for (genvar g = 0; g < QBITS; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[g]),
            .i_stage (c_st[g]),
            .o_vld   (c_vld[g+1]),
            .o_stage (c_st[g+1])
        );
    end

    // Sign the quotient magnitudes and clamp; a quotient bit above the top
    // word was caught up front as overflow.
    always_comb begin
        last = c_st[QBITS];
        q_re = sat32(last.neg_re ? -SUM_W'(last.s_re) : SUM_W'(last.s_re));
        q_im = sat32(last.neg_im ? -SUM_W'(last.s_im) : SUM_W'(last.s_im));
        if (last.ovf_re) begin
            q_re.v = last.neg_re ? W_MIN : W_MAX;
            q_re.s = 1'b1;
        end
        if (last.ovf_im) begin
            q_im.v = last.neg_im ? W_MIN : W_MAX;
            q_im.s = 1'b1;
        end
        if (!last.dv) begin
            n_res.w_re   = last.s_re;
            n_res.w_im   = last.s_im;
            n_res.status = last.sat ? ST_SAT : ST_OK;
        end else if (last.dz) begin
            n_res.w_re   = '0;
            n_res.w_im   = '0;
            n_res.status = ST_DZ;
        end else begin
            n_res.w_re   = q_re.v;
            n_res.w_im   = q_im.v;
            n_res.status = (q_re.s | q_im.s) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= c_vld[QBITS];
        end
        r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_DZ |-> o_result.w_re == '0 && o_result.w_im == '0)
        else $error("divide by zero result not cleared");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_result.status != 2'd3)
        else $error("invalid status code");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_SAT |->
            o_result.w_re == W_MAX || o_result.w_re == W_MIN ||
            o_result.w_im == W_MAX || o_result.w_im == W_MIN)
        else $error("saturation flagged without a clamped part");

endmodule

@@ tb/complex_arithmetic_unit_test.sv @@
// Testbench for complex_arithmetic_unit: directed corner items, then random items,
// each result checked against a bit-exact predictor of the arithmetic.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module complex_arithmetic_unit_test;
    import cau_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1750;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_result;
    int   n_errors;

    complex_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // Clamp an exact value to 32 bits; flag when the value did not fit.
    function automatic logic [31:0] clamp32(input logic signed [127:0] x,
                                            inout logic sat);
        if (x > 128'sh7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (x < -128'sh8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return x[31:0];
    endfunction

    // Truncating quotient num * 2^FRAC / den; a quotient too large for the
    // integer part becomes a clamped value of the numerator's sign.
    function automatic logic [31:0] quotient(input logic signed [127:0] num,
                                             input logic [127:0] den, inout logic sat);
        logic [127:0]        mag;
        logic [127:0]        q;
        logic signed [127:0] v;
        mag = num < 0 ? 128'(-num) : 128'(num);
        if (mag / den >= (128'd1 << (32 - FRAC)))
            q = 128'd1 << 32;
        else
            q = (mag << FRAC) / den;
        v = num < 0 ? -$signed(q) : $signed(q);
        return clamp32(v, sat);
    endfunction

    // Work out the expected result of one item.
    function automatic t_out complex_result(input t_in it);
        t_out r;
        logic signed [127:0] a, b, c, d;
        logic [127:0]        den;
        logic                sat;
        logic [2:0]          op;
        a = it.y_re; b = it.y_im; c = it.z_re; d = it.z_im;
        op = it.op;
        sat = 1'b0;
        r = '0;
        r.status = ST_OK;
        if (op == OP_RCP) begin
            a = 128'sd1 <<< FRAC;
            b = 0;
            op = OP_DIV;
        end
        case (op)
            OP_ADD: begin
                r.w_re = clamp32(a + c, sat);
                r.w_im = clamp32(b + d, sat);
            end
            OP_SUB: begin
                r.w_re = clamp32(a - c, sat);
                r.w_im = clamp32(b - d, sat);
            end
            OP_MUL: begin
                // arithmetic shift floors toward minus infinity
                r.w_re = clamp32((a * c - b * d) >>> FRAC, sat);
                r.w_im = clamp32((a * d + b * c) >>> FRAC, sat);
            end
            OP_DIV: begin
                den = 128'(c * c + d * d);
                if (den == 0)
                    r.status = ST_DZ;
                else begin
                    r.w_re = quotient(a * c + b * d, den, sat);
                    r.w_im = quotient(b * c - a * d, den, sat);
                end
            end
            OP_CNJ: begin
                r.w_re = clamp32(c, sat);
                r.w_im = clamp32(-d, sat);
            end
            default: ;
        endcase
        if (r.status == ST_OK && sat)
            r.status = ST_SAT;
        return r;
    endfunction

    class result_board;
        t_out pending[$];

        function void note_item(t_in it);
            pending.push_back(complex_result(it));
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.w_re, 32'h0);
                return;
            end
            want = pending.pop_front();
            if (got.w_re !== want.w_re) report_mismatch("w_re", got.w_re, want.w_re);
            if (got.w_im !== want.w_im) report_mismatch("w_im", got.w_im, want.w_im);
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    result_board board;

    // Pick a gap before the next item: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Operand word: corner values, small Q16.16 numbers, or any bit pattern.
    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                case ($urandom_range(0, 6))
                    0: return 32'h0;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h0001_0000;
                    4: return 32'hFFFF_0000;
                    5: return 32'h1;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4, 5: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            6: return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
            default: return $urandom;
        endcase
    endfunction

    // Present one item after a gap and hold it until the block accepts it.
    task automatic send_item(input t_in it, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_item(it);
    endtask

    task automatic send_ops(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d);
        t_in it;
        for (int k = 0; k < 8; k++) begin
            it = '{op: 3'(k), y_re: a, y_im: b, z_re: c, z_im: d};
            send_item(it, 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            board.check_result(o_result);
    end

    initial begin
        t_in it;
        board = new();
        n_errors = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every op (unused codes too) on small, extreme and zero operands.
        send_ops(32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0003_0000);
        send_ops(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // zero divisor for divide and reciprocal
        send_ops(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
        it = '{op: OP_RCP, y_re: 32'h0, y_im: 32'h0, z_re: 32'h0000_0001, z_im: 32'h0};
        send_item(it, 0);

        // Random: mostly valid ops, a few unused codes.
        for (int n = 0; n < N_RANDOM; n++) begin
            it.op   = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                   : 3'($urandom_range(0, 5));
            it.y_re = pick_word();
            it.y_im = pick_word();
            it.z_re = pick_word();
            it.z_im = pick_word();
            // bursts with no gaps now and then
            send_item(it, (n % 200 < 40) ? 0 : pick_gap());
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0)
            $display("complex_arithmetic_unit_test: done, clean");
        else
            $display("complex_arithmetic_unit_test: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("complex_arithmetic_unit_test: done, errors");
        $finish;
    end

endmodule
